FILE: design/i2cms_pkg.sv
// shared types and constants of the i2c master transaction sequencer
// no dependencies; imported by i2cms_ctrl, i2cms_out, the top level and the testbench

package i2cms_pkg;

  // payload buffer geometry
  localparam int MAX_PAYLOAD = 32;
  localparam int BUF_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  // request modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_EVENT = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // bus controller commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_RACK  = 3'd3;
  localparam logic [2:0] CMD_RNACK = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;
  localparam logic [2:0] CMD_RESET = 3'd6;

  // expected bus status codes
  localparam logic [7:0] ST_START  = 8'h08;
  localparam logic [7:0] ST_RSTART = 8'h10;
  localparam logic [7:0] ST_WDATA  = 8'h28;
  localparam logic [7:0] ST_RACK   = 8'h50;
  localparam logic [7:0] ST_RNACK  = 8'h58;
  localparam logic [7:0] ST_MASK   = 8'hF8;

  // error kinds
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_STATUS  = 2'd2;

  // transaction phase
  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_START  = 9'b000000010,
    PH_ADDRW  = 9'b000000100,
    PH_REG    = 9'b000001000,
    PH_WDATA  = 9'b000010000,
    PH_RSTART = 9'b000100000,
    PH_ADDRR  = 9'b001000000,
    PH_RDATA  = 9'b010000000,
    PH_STOP   = 9'b100000000
  } phase_e;

  // one input request
  typedef struct packed {
    logic [7:0] bus_data;
    logic [7:0] bus_status;
    logic [7:0] load_byte;
    logic [5:0] length;
    logic       is_read;
    logic       use_reg;
    logic [7:0] reg_addr;
    logic [6:0] dev_addr;
    logic [1:0] mode;
  } item_t;

  // one staged result; bus_byte comes from the buffer when use_mem is set
  typedef struct packed {
    logic [15:0] lockups;
    logic [7:0]  err_status;
    logic [1:0]  err_kind;
    logic        done_res;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        use_mem;
    logic [7:0]  bus_byte;
    logic [2:0]  bus_cmd;
  } res_t;

endpackage

FILE: design/i2cms_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/i2cms_ctrl.sv
// transaction control: phase decode, status checks, timeout and lockup count
// depends on i2cms_pkg; drives the payload ram ports and the result stage

module i2cms_ctrl import i2cms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             item_i,
  input  logic              s2_pop_i,
  output logic              s2_valid_o,
  output res_t              s2_o,
  output logic              ram_we_o,
  output logic [BUF_AW-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              ram_re_o,
  output logic [BUF_AW-1:0] ram_raddr_o
);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [6:0]       t_addr_q, t_addr_d;
  logic [7:0]       t_reg_q, t_reg_d;
  logic             t_usereg_q, t_usereg_d;
  logic             t_read_q, t_read_d;
  logic [CNT_W-1:0] t_len_q, t_len_d;
  logic [15:0]      wait_q, wait_d;
  logic [15:0]      lock_q, lock_d;
  logic [15:0]      tmo_q;
  logic             s2_valid_q;
  res_t             s2_q;

  logic             accept;
  logic             has_res;
  res_t             res;
  logic [7:0]       st;
  logic [CNT_W:0]   idx_p1;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W:0]   inc_p1;
  logic [15:0]      wait_n;
  logic [7:0]       len_w;
  logic [7:0]       len_c;

  assign in_ready_o = !s2_valid_q || s2_pop_i;
  assign accept     = in_valid_i && in_ready_o;

  assign st      = item_i.bus_status & ST_MASK;
  assign idx_p1  = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
  assign idx_inc = idx_p1[CNT_W-1:0];
  assign inc_p1  = {1'b0, idx_inc} + {{CNT_W{1'b0}}, 1'b1};
  assign wait_n  = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;
  assign len_w   = {2'b00, item_i.length};

  // length clamp for a start request; a zero-length read is taken as one byte
  always_comb begin
    len_c = (len_w > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD) : len_w;
    if (item_i.is_read && len_c == 8'd0) begin
      len_c = 8'd1;
    end
  end

  // next state and result of the accepted request
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    t_addr_d    = t_addr_q;
    t_reg_d     = t_reg_q;
    t_usereg_d  = t_usereg_q;
    t_read_d    = t_read_q;
    t_len_d     = t_len_q;
    wait_d      = wait_q;
    lock_d      = lock_q;
    has_res     = 1'b0;
    res         = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[BUF_AW-1:0];
    ram_wdata_o = item_i.load_byte;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    if (accept) begin
      unique case (item_i.mode)
        MODE_START: begin
          if (phase_q == PH_IDLE) begin
            t_addr_d    = item_i.dev_addr;
            t_reg_d     = item_i.reg_addr;
            t_usereg_d  = item_i.use_reg;
            t_read_d    = item_i.is_read;
            t_len_d     = len_c[CNT_W-1:0];
            idx_d       = '0;
            cnt_d       = '0;
            phase_d     = PH_START;
            wait_d      = '0;
            has_res     = 1'b1;
            res.bus_cmd = CMD_START;
          end
        end
        MODE_LOAD: begin
          if (phase_q == PH_IDLE && cnt_q < CNT_W'(MAX_PAYLOAD)) begin
            ram_we_o = 1'b1;
            cnt_d    = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
        MODE_EVENT: begin
          if (phase_q != PH_IDLE) begin
            has_res = 1'b1;
            wait_d  = '0;
            unique case (phase_q) inside
              PH_START, PH_RSTART: begin
                if (st != ST_START && st != ST_RSTART) begin
                  lock_d         = lock_q + 16'd1;
                  phase_d        = PH_IDLE;
                  wait_d         = wait_q;
                  res.done_res   = 1'b1;
                  res.err_kind   = ERR_STATUS;
                  res.err_status = st;
                end else begin
                  res.bus_cmd  = CMD_SEND;
                  res.bus_byte = {t_addr_q, (phase_q == PH_RSTART)};
                  phase_d      = (phase_q == PH_RSTART) ? PH_ADDRR : PH_ADDRW;
                end
              end
              PH_ADDRW, PH_REG: begin
                if (phase_q == PH_REG && st != ST_WDATA) begin
                  lock_d         = lock_q + 16'd1;
                  phase_d        = PH_IDLE;
                  wait_d         = wait_q;
                  res.done_res   = 1'b1;
                  res.err_kind   = ERR_STATUS;
                  res.err_status = st;
                end else if (phase_q == PH_ADDRW && t_usereg_q) begin
                  res.bus_cmd  = CMD_SEND;
                  res.bus_byte = t_reg_q;
                  phase_d      = PH_REG;
                end else if (t_read_q) begin
                  res.bus_cmd = CMD_START;
                  phase_d     = PH_RSTART;
                end else begin
                  idx_d = '0;
                  if (t_len_q != '0) begin
                    res.bus_cmd = CMD_SEND;
                    res.use_mem = 1'b1;
                    ram_re_o    = 1'b1;
                    ram_raddr_o = '0;
                    phase_d     = PH_WDATA;
                  end else begin
                    res.bus_cmd = CMD_STOP;
                    phase_d     = PH_STOP;
                  end
                end
              end
              PH_WDATA: begin
                if (st != ST_WDATA) begin
                  lock_d         = lock_q + 16'd1;
                  phase_d        = PH_IDLE;
                  wait_d         = wait_q;
                  res.done_res   = 1'b1;
                  res.err_kind   = ERR_STATUS;
                  res.err_status = st;
                end else begin
                  idx_d = idx_inc;
                  if (idx_inc < t_len_q) begin
                    res.bus_cmd = CMD_SEND;
                    res.use_mem = 1'b1;
                    ram_re_o    = 1'b1;
                    ram_raddr_o = idx_inc[BUF_AW-1:0];
                  end else begin
                    res.bus_cmd = CMD_STOP;
                    phase_d     = PH_STOP;
                  end
                end
              end
              PH_ADDRR: begin
                idx_d       = '0;
                res.bus_cmd = (t_len_q <= {{(CNT_W-1){1'b0}}, 1'b1}) ? CMD_RNACK
                                                                      : CMD_RACK;
                phase_d     = PH_RDATA;
              end
              PH_RDATA: begin
                if (st != ((idx_p1 >= {1'b0, t_len_q}) ? ST_RNACK : ST_RACK)) begin
                  lock_d         = lock_q + 16'd1;
                  phase_d        = PH_IDLE;
                  wait_d         = wait_q;
                  res.done_res   = 1'b1;
                  res.err_kind   = ERR_STATUS;
                  res.err_status = st;
                end else begin
                  idx_d          = idx_inc;
                  res.read_valid = 1'b1;
                  res.read_byte  = item_i.bus_data;
                  if (idx_inc < t_len_q) begin
                    res.bus_cmd = (inc_p1 >= {1'b0, t_len_q}) ? CMD_RNACK : CMD_RACK;
                  end else begin
                    res.bus_cmd = CMD_STOP;
                    phase_d     = PH_STOP;
                  end
                end
              end
              PH_STOP: begin
                phase_d      = PH_IDLE;
                wait_d       = wait_q;
                res.done_res = 1'b1;
              end
              default: begin
                has_res = 1'b0;
                wait_d  = wait_q;
              end
            endcase
          end
        end
        MODE_TICK: begin
          if (phase_q != PH_IDLE && tmo_q != 16'd0) begin
            if (wait_n >= tmo_q) begin
              lock_d       = lock_q + 16'd2;
              phase_d      = PH_IDLE;
              wait_d       = '0;
              has_res      = 1'b1;
              res.bus_cmd  = CMD_RESET;
              res.done_res = 1'b1;
              res.err_kind = ERR_TIMEOUT;
            end else begin
              wait_d = wait_n;
            end
          end
        end
        default: begin
          has_res = 1'b0;
        end
      endcase
    end
    res.lockups = lock_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      t_addr_q   <= '0;
      t_reg_q    <= '0;
      t_usereg_q <= 1'b0;
      t_read_q   <= 1'b0;
      t_len_q    <= '0;
      wait_q     <= '0;
      lock_q     <= '0;
      tmo_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      t_addr_q   <= t_addr_d;
      t_reg_q    <= t_reg_d;
      t_usereg_q <= t_usereg_d;
      t_read_q   <= t_read_d;
      t_len_q    <= t_len_d;
      wait_q     <= wait_d;
      lock_q     <= lock_d;
      if (cfg_we_i) begin
        tmo_q <= cfg_wdata_i;
      end
      if (accept) begin
        s2_valid_q <= has_res;
      end else if (s2_pop_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // result stage payload, lines up with the ram read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_q <= res;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

endmodule

FILE: design/i2cms_out.sv
// output register: merges the buffer read data into the result and holds it
// depends on i2cms_pkg

module i2cms_out import i2cms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s2_valid_i,
  input  res_t        s2_i,
  input  logic [7:0]  ram_rdata_i,
  output logic        s2_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] out_data_o
);

  logic        valid_q;
  logic [47:0] data_q;
  logic [7:0]  byte_sel;

  assign s2_pop_o = s2_valid_i && (!valid_q || out_ready_i);
  assign byte_sel = s2_i.use_mem ? ram_rdata_i : s2_i.bus_byte;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s2_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // packed result
  always_ff @(posedge clk_i) begin
    if (s2_pop_o) begin
      data_q <= {1'b0, s2_i.lockups, s2_i.err_status, s2_i.err_kind, s2_i.done_res,
                 s2_i.read_byte, s2_i.read_valid, byte_sel, s2_i.bus_cmd};
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: design/i2c_master_transaction_sequencer.sv
// top level of the i2c master transaction sequencer
// depends on i2cms_pkg, i2cms_ram, i2cms_ctrl and i2cms_out
//
// requests enter on the s_axis channel: tuser carries the mode (start,
// load write byte, bus completion, millisecond tick), tdata the fields.
// each request yields zero or one result on the m_axis channel: the next
// bus controller command with its byte, a received byte, and the end of a
// transaction with its error kind and the running lockup count.
// a request is taken every cycle while s_axis_tready is high; its result
// passes through the result stage, which lines up with the payload ram
// read, and then the output register before it shows on m_axis_tvalid.
// write payload bytes sit in a 32-entry ram; loads are taken only while no
// transaction runs. the user must write timeout_ms through cfg_we_i/cfg_wdata_i
// only while the block is idle (the block does not enforce it); 0 disables the timeout.
// reset returns to idle with an empty buffer, zero lockup count and
// timeout 0; the buffer contents are not cleared. when m_axis_tready is
// low the output register and the result stage fill, then s_axis_tready
// drops until results drain; nothing is lost.

module i2c_master_transaction_sequencer import i2cms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dev_addr[6:0] reg_addr[14:7] use_reg[15] is_read[16] length[22:17]
  // load_byte[30:23] bus_status[38:31] bus_data[46:39], zero [47]
  input  logic [47:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bus_cmd[2:0] bus_byte[10:3] read_valid[11] read_byte[19:12]
  // done_res[20] err_kind[22:21] err_status[30:23] lockups[46:31], zero [47]
  output logic [47:0] m_axis_tdata
);

  item_t             item;
  res_t              s2;
  logic              s2_valid;
  logic              s2_pop;
  logic              ram_we;
  logic [BUF_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [BUF_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // unpack the request
  assign item.mode       = s_axis_tuser;
  assign item.dev_addr   = s_axis_tdata[6:0];
  assign item.reg_addr   = s_axis_tdata[14:7];
  assign item.use_reg    = s_axis_tdata[15];
  assign item.is_read    = s_axis_tdata[16];
  assign item.length     = s_axis_tdata[22:17];
  assign item.load_byte  = s_axis_tdata[30:23];
  assign item.bus_status = s_axis_tdata[38:31];
  assign item.bus_data   = s_axis_tdata[46:39];

  // transaction control
  i2cms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .s2_pop_i    (s2_pop),
    .s2_valid_o  (s2_valid),
    .s2_o        (s2),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  // write payload buffer
  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (BUF_AW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  i2cms_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_i        (s2),
    .ram_rdata_i (ram_rdata),
    .s2_pop_o    (s2_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: dv/i2c_master_transaction_sequencer_test.sv
// self-checking testbench of the i2c master transaction sequencer: a short
// directed table, then random transactions under several timeouts
// depends on i2cms_pkg and i2c_master_transaction_sequencer

module i2c_master_transaction_sequencer_test;
  import i2cms_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 6;
  localparam int LIVE_PER_SET = 60;
  localparam int STALL_AFTER  = 200;
  localparam int STALL_CYCLES = 120;

  // one result as it leaves on m_axis_tdata, bus_cmd in the lowest bits
  typedef struct packed {
    logic        pad;
    logic [15:0] lockups;
    logic [7:0]  err_status;
    logic [1:0]  err_kind;
    logic        done_res;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic [7:0]  bus_byte;
    logic [2:0]  bus_cmd;
  } bus_result_t;

  // directed row: request fields, then an optional hand-written result
  typedef struct {
    logic [1:0]  mode;
    logic [6:0]  dev;
    logic [7:0]  regb;
    logic        use_reg;
    logic        rd;
    logic [5:0]  len;
    logic [7:0]  ld;
    logic [7:0]  st;
    logic [7:0]  dat;
    bit          typed;
    logic [2:0]  cmd;
    logic [7:0]  byt;
    logic        rv;
    logic [7:0]  rb;
    logic        done;
    logic [1:0]  ek;
    logic [7:0]  es;
    logic [15:0] lk;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  // sequencer state as predicted
  phase_e      seq_phase = PH_IDLE;
  logic [7:0]  pay_buf [MAX_PAYLOAD];
  int          pay_cnt = 0;
  int          pay_filled = 0;
  logic [5:0]  byte_idx = '0;
  logic [6:0]  txn_addr = '0;
  logic [7:0]  txn_reg = '0;
  logic        txn_usereg = 1'b0;
  logic        txn_read = 1'b0;
  logic [5:0]  txn_len = '0;
  logic [15:0] tick_cnt = '0;
  logic [15:0] lockup_cnt = '0;
  logic [15:0] tmo_ms = '0;
  bit          step_live;

  bus_result_t pending_results [$];
  bus_result_t seen_res;
  bus_result_t oldest_res;

  int          cycle_cnt = 0;
  int          sent_cnt = 0;
  int          live_cnt = 0;
  int          checked_cnt = 0;
  int          mismatch_cnt = 0;
  int          txn_done_cnt = 0;
  int          status_err_cnt = 0;
  int          timeout_cnt = 0;
  int          burst_left = 0;
  int          load_run = 0;
  bit          long_stall_done = 1'b0;
  logic [15:0] tmo_plan [6];

  dir_row_t dir_rows [25] = '{
    // tick and bus event while idle
    '{MODE_TICK, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'hFF, 8'hFF,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    // three payload bytes
    '{MODE_LOAD, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'hFF, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_LOAD, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_LOAD, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'hA5, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    // register write of two bytes to the top address
    '{MODE_START, 7'h7F, 8'hFF, 1'b1, 1'b0, 6'd2, 8'h00, 8'h00, 8'h00,
      1'b1, CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h08, 8'h00,
      1'b1, CMD_SEND, 8'hFE, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h1F, 8'h00,
      1'b1, CMD_SEND, 8'hFF, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h28, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    // start and load while busy are dropped
    '{MODE_START, 7'h01, 8'h00, 1'b0, 1'b1, 6'd5, 8'h00, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_LOAD, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h77, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    // low status bits are ignored
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h2F, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h28, 8'h00,
      1'b1, CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'hFF, 8'h00,
      1'b1, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ERR_OK, 8'h00, 16'd0},
    // read of length 0 from address 0, taken as one byte
    '{MODE_START, 7'h00, 8'h00, 1'b0, 1'b1, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b1, CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h10, 8'h00,
      1'b1, CMD_SEND, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b1, CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h08, 8'h00,
      1'b1, CMD_SEND, 8'h01, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b1, CMD_RNACK, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h58, 8'hC3,
      1'b1, CMD_STOP, 8'h00, 1'b1, 8'hC3, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b1, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ERR_OK, 8'h00, 16'd0},
    // oversized read, then a bad start status
    '{MODE_START, 7'h55, 8'h12, 1'b1, 1'b1, 6'd63, 8'h00, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'hE7, 8'h00,
      1'b1, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ERR_STATUS, 8'hE0, 16'd1},
    // empty write ended by a timeout of one tick
    '{MODE_START, 7'h01, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b0, CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ERR_OK, 8'h00, 16'd0},
    '{MODE_TICK, 7'h00, 8'h00, 1'b0, 1'b0, 6'd0, 8'h00, 8'h00, 8'h00,
      1'b1, CMD_RESET, 8'h00, 1'b0, 8'h00, 1'b1, ERR_TIMEOUT, 8'h00, 16'd3}
  };

  i2c_master_transaction_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic bus_result_t make_result(input logic [2:0] cmd, input logic [7:0] byt,
                                              input logic rv, input logic [7:0] rb,
                                              input logic done, input logic [1:0] ek,
                                              input logic [7:0] es);
    bus_result_t r;
    r = '0;
    r.bus_cmd    = cmd;
    r.bus_byte   = byt;
    r.read_valid = rv;
    r.read_byte  = rb;
    r.done_res   = done;
    r.err_kind   = ek;
    r.err_status = es;
    r.lockups    = lockup_cnt;
    return r;
  endfunction

  // next bus command; restarts the timeout count
  function automatic bus_result_t issue_cmd(input phase_e nxt, input logic [2:0] cmd,
                                            input logic [7:0] byt, input logic rv,
                                            input logic [7:0] rb);
    seq_phase = nxt;
    tick_cnt  = '0;
    return make_result(cmd, byt, rv, rb, 1'b0, ERR_OK, 8'h00);
  endfunction

  // write or register byte done: on to the data, the repeated start or the stop
  function automatic bus_result_t after_header();
    if (txn_read) return issue_cmd(PH_RSTART, CMD_START, 8'h00, 1'b0, 8'h00);
    byte_idx = '0;
    if (txn_len != 0) return issue_cmd(PH_WDATA, CMD_SEND, pay_buf[0], 1'b0, 8'h00);
    return issue_cmd(PH_STOP, CMD_STOP, 8'h00, 1'b0, 8'h00);
  endfunction

  // does a status satisfy the command in flight; phases that accept any return 1
  function automatic bit status_ok(input logic [7:0] st);
    logic [7:0] m;
    m = st & ST_MASK;
    case (seq_phase) inside
      PH_START, PH_RSTART: return (m == ST_START) || (m == ST_RSTART);
      PH_REG, PH_WDATA:    return m == ST_WDATA;
      PH_RDATA:            return m == ((byte_idx + 1 >= txn_len) ? ST_RNACK : ST_RACK);
      default:             return 1'b1;
    endcase
  endfunction

  function automatic bit strict_phase();
    return seq_phase inside {PH_START, PH_RSTART, PH_REG, PH_WDATA, PH_RDATA};
  endfunction

  // one accepted request; returns 1 with the result it causes
  function automatic bit predict_bus_step(input item_t it, output bus_result_t r);
    int unsigned len;
    logic [7:0]  st;
    r = '0;
    step_live = 1'b0;
    case (it.mode)
      MODE_START: begin
        if (seq_phase != PH_IDLE) return 1'b0;
        len = it.length;
        if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
        if (it.is_read && len == 0) len = 1;
        txn_addr   = it.dev_addr;
        txn_reg    = it.reg_addr;
        txn_usereg = it.use_reg;
        txn_read   = it.is_read;
        txn_len    = len[5:0];
        byte_idx   = '0;
        pay_cnt    = 0;
        r = issue_cmd(PH_START, CMD_START, 8'h00, 1'b0, 8'h00);
      end
      MODE_LOAD: begin
        if (seq_phase == PH_IDLE && pay_cnt < MAX_PAYLOAD) begin
          pay_buf[pay_cnt] = it.load_byte;
          pay_cnt++;
          if (pay_cnt > pay_filled) pay_filled = pay_cnt;
          step_live = 1'b1;
        end
        return 1'b0;
      end
      MODE_EVENT: begin
        if (seq_phase == PH_IDLE) return 1'b0;
        st = it.bus_status & ST_MASK;
        if (!status_ok(st)) begin
          // wrong status: no stop, transaction dropped
          lockup_cnt = lockup_cnt + 16'd1;
          seq_phase  = PH_IDLE;
          status_err_cnt++;
          r = make_result(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ERR_STATUS, st);
        end else begin
          case (seq_phase)
            PH_START: r = issue_cmd(PH_ADDRW, CMD_SEND, {txn_addr, 1'b0}, 1'b0, 8'h00);
            PH_ADDRW: begin
              if (txn_usereg) r = issue_cmd(PH_REG, CMD_SEND, txn_reg, 1'b0, 8'h00);
              else r = after_header();
            end
            PH_REG: r = after_header();
            PH_WDATA: begin
              byte_idx = byte_idx + 6'd1;
              if (byte_idx < txn_len)
                r = issue_cmd(PH_WDATA, CMD_SEND, pay_buf[byte_idx], 1'b0, 8'h00);
              else
                r = issue_cmd(PH_STOP, CMD_STOP, 8'h00, 1'b0, 8'h00);
            end
            PH_RSTART: r = issue_cmd(PH_ADDRR, CMD_SEND, {txn_addr, 1'b1}, 1'b0, 8'h00);
            PH_ADDRR: begin
              byte_idx = '0;
              r = issue_cmd(PH_RDATA, (txn_len <= 1) ? CMD_RNACK : CMD_RACK,
                            8'h00, 1'b0, 8'h00);
            end
            PH_RDATA: begin
              byte_idx = byte_idx + 6'd1;
              if (byte_idx < txn_len)
                r = issue_cmd(PH_RDATA, (byte_idx + 1 >= txn_len) ? CMD_RNACK : CMD_RACK,
                              8'h00, 1'b1, it.bus_data);
              else
                r = issue_cmd(PH_STOP, CMD_STOP, 8'h00, 1'b1, it.bus_data);
            end
            default: begin
              // stop completed, any status
              seq_phase = PH_IDLE;
              txn_done_cnt++;
              r = make_result(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ERR_OK, 8'h00);
            end
          endcase
        end
      end
      default: begin
        if (seq_phase == PH_IDLE || tmo_ms == 0) return 1'b0;
        step_live = 1'b1;
        if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt < tmo_ms) return 1'b0;
        // lockup: release the bus and count two
        lockup_cnt = lockup_cnt + 16'd2;
        seq_phase  = PH_IDLE;
        tick_cnt   = '0;
        timeout_cnt++;
        r = make_result(CMD_RESET, 8'h00, 1'b0, 8'h00, 1'b1, ERR_TIMEOUT, 8'h00);
      end
    endcase
    step_live = 1'b1;
    return 1'b1;
  endfunction

  // ---------------- stimulus ----------------

  // random request shaped by the predicted phase
  function automatic item_t make_request();
    item_t         it;
    logic [63:0]   raw;
    int unsigned   pick;
    int unsigned   len;
    raw  = {$urandom, $urandom};
    it   = raw[$bits(item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (seq_phase == PH_IDLE) begin
      if (load_run > 0) begin
        it.mode = MODE_LOAD;
        load_run--;
      end else if (pick < 6) begin
        it.mode = (pick < 3) ? MODE_EVENT : MODE_TICK;
      end else if (pick < 35) begin
        // a run of loads, now and then past a full buffer
        load_run = ($urandom_range(0, 5) == 0) ? 34 : $urandom_range(1, 6);
        it.mode = MODE_LOAD;
        load_run--;
      end else begin
        it.mode = MODE_START;
        it.length = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 4))
                                               : 6'($urandom_range(0, 63));
        len = (it.length > MAX_PAYLOAD) ? MAX_PAYLOAD : it.length;
        // a write only reads back buffer entries loaded at some point
        if (!it.is_read && len > pay_filled) it.length = 6'($urandom_range(0, pay_filled));
      end
    end else begin
      if (pick < 80) begin
        it.mode = MODE_EVENT;
        while (!status_ok(it.bus_status)) it.bus_status = 8'($urandom);
      end else if (pick < 86) begin
        it.mode = MODE_EVENT;
        if (strict_phase())
          repeat (64) if (status_ok(it.bus_status)) it.bus_status = 8'($urandom);
      end else if (pick < 94) begin
        it.mode = MODE_TICK;
      end else if (pick < 97) begin
        it.mode = MODE_START;
      end else begin
        it.mode = MODE_LOAD;
      end
    end
    return it;
  endfunction

  // offer one request in bursts with gaps, then predict its result
  task automatic push_request(input item_t it, input bit typed, input bus_result_t want);
    bus_result_t pred_res;
    bit          has_res;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it[$bits(item_t)-1:2]};
    s_axis_tuser  <= it.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
    has_res = predict_bus_step(it, pred_res);
    if (step_live) live_cnt++;
    if (typed) pending_results.push_back(want);
    else if (has_res) pending_results.push_back(pred_res);
  endtask

  // drop valid and wait until every result is back and the pipe is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tmo_ms = v;
  endtask

  // ---------------- result side ----------------

  task automatic flag_result(input string why, input bus_result_t want,
                             input bus_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("tb: %s at cycle %0d", why, cycle_cnt);
      $display("  want cmd=%0d byte=%h rv=%b rb=%h done=%b err=%0d st=%h lockups=%0d",
               want.bus_cmd, want.bus_byte, want.read_valid, want.read_byte,
               want.done_res, want.err_kind, want.err_status, want.lockups);
      $display("  got  cmd=%0d byte=%h rv=%b rb=%h done=%b err=%0d st=%h lockups=%0d",
               got.bus_cmd, got.bus_byte, got.read_valid, got.read_byte,
               got.done_res, got.err_kind, got.err_status, got.lockups);
    end
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    int unsigned style;
    int unsigned span;
    @(posedge rst_ni);
    forever begin
      if (!long_stall_done && sent_cnt >= STALL_AFTER) begin
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        long_stall_done = 1'b1;
      end
      style = $urandom_range(0, 2);
      span  = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res = m_axis_tdata;
      if (pending_results.size() == 0) begin
        flag_result("result with nothing pending", '0, seen_res);
      end else begin
        oldest_res = pending_results.pop_front();
        checked_cnt++;
        if (seen_res.bus_cmd !== oldest_res.bus_cmd ||
            seen_res.bus_byte !== oldest_res.bus_byte ||
            seen_res.read_valid !== oldest_res.read_valid ||
            seen_res.read_byte !== oldest_res.read_byte ||
            seen_res.done_res !== oldest_res.done_res ||
            seen_res.err_kind !== oldest_res.err_kind ||
            seen_res.err_status !== oldest_res.err_status ||
            seen_res.lockups !== oldest_res.lockups)
          flag_result("result mismatch", oldest_res, seen_res);
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    item_t       it;
    bus_result_t want;
    int          goal;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, run with a one-tick timeout
    write_timeout(16'd1);
    foreach (dir_rows[i]) begin
      it = '0;
      it.mode       = dir_rows[i].mode;
      it.dev_addr   = dir_rows[i].dev;
      it.reg_addr   = dir_rows[i].regb;
      it.use_reg    = dir_rows[i].use_reg;
      it.is_read    = dir_rows[i].rd;
      it.length     = dir_rows[i].len;
      it.load_byte  = dir_rows[i].ld;
      it.bus_status = dir_rows[i].st;
      it.bus_data   = dir_rows[i].dat;
      want = '0;
      want.bus_cmd    = dir_rows[i].cmd;
      want.bus_byte   = dir_rows[i].byt;
      want.read_valid = dir_rows[i].rv;
      want.read_byte  = dir_rows[i].rb;
      want.done_res   = dir_rows[i].done;
      want.err_kind   = dir_rows[i].ek;
      want.err_status = dir_rows[i].es;
      want.lockups    = dir_rows[i].lk;
      push_request(it, dir_rows[i].typed, want);
    end
    settle();

    // random transactions under several timeout settings
    tmo_plan = '{16'd0, 16'hFFFF, 16'd2, 16'd0, 16'd1, 16'd7};
    tmo_plan[2] = 16'($urandom_range(2, 6));
    tmo_plan[5] = 16'($urandom_range(3, 12));
    foreach (tmo_plan[k]) begin
      write_timeout(tmo_plan[k]);
      goal = live_cnt + LIVE_PER_SET;
      while (live_cnt < goal) push_request(make_request(), 1'b0, '0);
      settle();
    end

    if (pending_results.size() != 0) begin
      $display("tb: %0d predicted results never arrived", pending_results.size());
      mismatch_cnt += pending_results.size();
    end
    $display("tb: %0d requests sent (%0d with effect), %0d results checked, %0d mismatches",
             sent_cnt, live_cnt, checked_cnt, mismatch_cnt);
    $display("tb: %0d transactions closed, %0d status errors, %0d timeouts, final lockups %0d",
             txn_done_cnt, status_err_cnt, timeout_cnt, lockup_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
